@@ src/sct_pkg.sv @@
package sct_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_LITERALS_DEF = 16;
  localparam int VAR_BITS_DEF     = 16;

  // Width of every count field in a result word
  localparam int COUNT_W = 5;

  // Stored entry layout: {variable, polarity, mark}
  localparam int MARK_W = 2;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TRUE     = 2'd1,
    CMD_FALSE    = 2'd2,
    CMD_UNASSIGN = 2'd3
  } cmd_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_OPEN  = 2'd0,
    MARK_TRUE  = 2'd1,
    MARK_FALSE = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_CHECK,
    ST_FIND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic run;
    logic find_open;
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } scan_sts_t;

endpackage

@@ src/sct_if.sv @@
interface sct_cmd_if #(
  parameter int VAR_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [VAR_BITS-1:0] variable_id;
  logic                polarity;

  modport source (output valid, output cmd, output variable_id, output polarity, input ready);
  modport sink   (input valid, input cmd, input variable_id, input polarity, output ready);
endinterface

interface sct_res_if #(
  parameter int VAR_BITS = 16
);
  import sct_pkg::*;

  logic                valid;
  logic                ready;
  logic                accepted;
  logic                conflict;
  logic                unit;
  logic [VAR_BITS-1:0] unit_variable;
  logic                unit_polarity;
  logic [COUNT_W-1:0]  true_count;
  logic [COUNT_W-1:0]  false_count;
  logic [COUNT_W-1:0]  unassigned_count;
  logic [COUNT_W-1:0]  literal_count;

  modport source (
    output valid, output accepted, output conflict, output unit,
    output unit_variable, output unit_polarity, output true_count,
    output false_count, output unassigned_count, output literal_count,
    input ready
  );
  modport sink (
    input valid, input accepted, input conflict, input unit,
    input unit_variable, input unit_polarity, input true_count,
    input false_count, input unassigned_count, input literal_count,
    output ready
  );
endinterface

@@ src/sat_clause_state_tracker_unit.sv @@
// Channel   Dir  Modport          Payload
// cmd_ch    in   sct_cmd_if.sink   cmd, variable_id, polarity
// res_ch    out  sct_res_if.source accepted, conflict, unit, unit_variable,
//                                  unit_polarity, four 5-bit counts
//
// An add appends at the fill point, then the status is checked. An assign or
// unassign walks the literal table one entry a cycle through the single
// compare unit up to the first match or past the last stored literal. When
// the clause turns unit, the same unit walks the table again for the open
// literal.
// Reset (rst, synchronous) empties the clause; the table holds no reset.
// A stalled result holds in the output register; the next word is taken
// meanwhile, and its result waits until the register frees up.
module sat_clause_state_tracker_unit #(
  parameter int MAX_LITERALS = sct_pkg::MAX_LITERALS_DEF,
  parameter int VAR_BITS     = sct_pkg::VAR_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  sct_cmd_if.sink   cmd_ch,
  sct_res_if.source res_ch
);
  import sct_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LITERALS + 1);
  localparam int IDX_W  = MAX_LITERALS > 1 ? $clog2(MAX_LITERALS) : 1;
  localparam int WORD_W = VAR_BITS + MARK_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LITERALS);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  // Sequencer and clause counters
  state_t               state, state_next;
  logic [CNT_W-1:0]     stored, stored_next;
  logic [CNT_W-1:0]     ttot, ttot_next;
  logic [CNT_W-1:0]     ftot, ftot_next;
  logic [CNT_W-1:0]     otot, otot_next;

  // Command held for the duration of the walk
  cmd_e                 op, op_next;
  logic [VAR_BITS-1:0]  key, key_next;
  logic                 acc, acc_next;
  logic                 confl, confl_next;
  logic                 unit_r, unit_next;
  logic [VAR_BITS-1:0]  uvar, uvar_next;
  logic                 upol, upol_next;

  // Table port and scan unit
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [WORD_W-1:0]    wdata;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [WORD_W-1:0]    rd_data;
  logic [IDX_W-1:0]     hit_idx;
  scan_ctl_t            scan_ctl;
  scan_sts_t            scan_sts;

  logic [VAR_BITS-1:0]  hit_var;
  logic                 hit_pol;
  mark_e                hit_mark;
  mark_e                new_mark;

  // Output register
  logic                 res_valid;
  logic                 load_out;

  assign hit_var  = rd_data[WORD_W-1:MARK_W+1];
  assign hit_pol  = rd_data[MARK_W];
  assign hit_mark = mark_e'(rd_data[MARK_W-1:0]);

  sct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_LITERALS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sct_scan #(
    .MAX_LITERALS (MAX_LITERALS),
    .VAR_BITS     (VAR_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .key     (key),
    .limit   (stored),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .hit_idx (hit_idx),
    .sts     (scan_sts)
  );

  assign cmd_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      stored <= '0;
      ttot   <= '0;
      ftot   <= '0;
      otot   <= '0;
    end else begin
      state  <= state_next;
      stored <= stored_next;
      ttot   <= ttot_next;
      ftot   <= ftot_next;
      otot   <= otot_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    key    <= key_next;
    acc    <= acc_next;
    confl  <= confl_next;
    unit_r <= unit_next;
    uvar   <= uvar_next;
    upol   <= upol_next;
  end

  always_comb begin
    state_next  = state;
    stored_next = stored;
    ttot_next   = ttot;
    ftot_next   = ftot;
    otot_next   = otot;
    op_next     = op;
    key_next    = key;
    acc_next    = acc;
    confl_next  = confl;
    unit_next   = unit_r;
    uvar_next   = uvar;
    upol_next   = upol;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    scan_ctl    = '0;
    load_out    = 1'b0;
    new_mark    = MARK_OPEN;

    case (state)
      ST_IDLE: begin
        if (cmd_ch.valid) begin
          op_next  = cmd_e'(cmd_ch.cmd);
          key_next = cmd_ch.variable_id;
          acc_next = 1'b0;
          if (cmd_e'(cmd_ch.cmd) == CMD_ADD) begin
            // Append at the fill point; a full table drops the word
            if (stored < MAX_CNT) begin
              we          = 1'b1;
              waddr       = stored[IDX_W-1:0];
              wdata       = {cmd_ch.variable_id, cmd_ch.polarity, MARK_OPEN};
              stored_next = stored + ONE;
              otot_next   = otot + ONE;
              acc_next    = 1'b1;
            end
            state_next = ST_CHECK;
          end else begin
            scan_ctl.start = 1'b1;
            state_next     = ST_MATCH;
          end
        end
      end

      ST_MATCH: begin
        // Walk for the first entry on this variable
        scan_ctl.run = 1'b1;
        if (scan_sts.hit) begin
          case (op)
            CMD_UNASSIGN: begin
              if (hit_mark == MARK_TRUE || hit_mark == MARK_FALSE) begin
                if (hit_mark == MARK_TRUE) begin
                  ttot_next = ttot - ONE;
                end else begin
                  ftot_next = ftot - ONE;
                end
                otot_next = otot + ONE;
                new_mark  = MARK_OPEN;
                we        = 1'b1;
                acc_next  = 1'b1;
              end
            end
            default: begin
              if (hit_mark == MARK_OPEN) begin
                if (hit_pol == (op == CMD_TRUE)) begin
                  new_mark  = MARK_TRUE;
                  ttot_next = ttot + ONE;
                end else begin
                  new_mark  = MARK_FALSE;
                  ftot_next = ftot + ONE;
                end
                otot_next = otot - ONE;
                we        = 1'b1;
                acc_next  = 1'b1;
              end
            end
          endcase
          waddr      = hit_idx;
          wdata      = {hit_var, hit_pol, new_mark};
          state_next = ST_CHECK;
        end else if (scan_sts.miss) begin
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Clause status from the updated counts; rewind the walk
        scan_ctl.start     = 1'b1;
        scan_ctl.find_open = 1'b1;
        confl_next = (ftot == stored);
        unit_next  = ((stored - ftot) == ONE) && (otot == ONE);
        uvar_next  = '0;
        upol_next  = 1'b0;
        state_next = unit_next ? ST_FIND : ST_OUT;
      end

      ST_FIND: begin
        // Walk for the single open literal
        scan_ctl.run       = 1'b1;
        scan_ctl.find_open = 1'b1;
        if (scan_sts.hit) begin
          uvar_next  = hit_var;
          upol_next  = hit_pol;
          state_next = ST_OUT;
        end else if (scan_sts.miss) begin
          state_next = ST_OUT;
        end
      end

      ST_OUT: begin
        // Hold until the output register frees up
        if (!res_valid || res_ch.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_ch.accepted         <= acc;
      res_ch.conflict         <= confl;
      res_ch.unit             <= unit_r;
      res_ch.unit_variable    <= uvar;
      res_ch.unit_polarity    <= upol;
      res_ch.true_count       <= COUNT_W'(ttot);
      res_ch.false_count      <= COUNT_W'(ftot);
      res_ch.unassigned_count <= COUNT_W'(otot);
      res_ch.literal_count    <= COUNT_W'(stored);
    end
  end

  assign res_ch.valid = res_valid;

  // Every stored literal is counted exactly once
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    ((CNT_W+2)'(ttot) + (CNT_W+2)'(ftot) + (CNT_W+2)'(otot)) == (CNT_W+2)'(stored))
    else $error("literal counts do not add up to the fill level");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= MAX_CNT)
    else $error("fill level beyond table depth");

  // A unit clause always holds an open literal below the fill point
  a_find_hits: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIND |-> !scan_sts.miss)
    else $error("unit search found no open literal");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && cmd_ch.ready |=> !cmd_ch.ready)
    else $error("ready while a word is still in work");

endmodule

@@ src/sct_ram.sv @@
module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sct_scan.sv @@
module sct_scan #(
  parameter int MAX_LITERALS = 16,
  parameter int VAR_BITS     = 16
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  sct_pkg::scan_ctl_t                                  ctl,
  input  logic [VAR_BITS-1:0]                                 key,
  input  logic [$clog2(MAX_LITERALS+1)-1:0]                   limit,
  input  logic [VAR_BITS+sct_pkg::MARK_W:0]                   rd_data,
  output logic                                                rd_en,
  output logic [(MAX_LITERALS > 1 ? $clog2(MAX_LITERALS) : 1)-1:0] rd_addr,
  output logic [(MAX_LITERALS > 1 ? $clog2(MAX_LITERALS) : 1)-1:0] hit_idx,
  output sct_pkg::scan_sts_t                                  sts
);
  import sct_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LITERALS + 1);
  localparam int IDX_W  = MAX_LITERALS > 1 ? $clog2(MAX_LITERALS) : 1;
  localparam int WORD_W = VAR_BITS + MARK_W + 1;

  logic [CNT_W-1:0] cnt;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             key_hit;

  // Shared compare: variable match, or open mark during the unit search
  always_comb begin
    if (ctl.find_open) begin
      key_hit = (rd_data[MARK_W-1:0] == MARK_OPEN);
    end else begin
      key_hit = (rd_data[WORD_W-1:MARK_W+1] == key);
    end
  end

  assign sts.hit  = ctl.run && chk_valid && key_hit;
  assign sts.miss = ctl.run && !sts.hit && (cnt == limit);
  assign rd_en    = ctl.run && !sts.hit && (cnt < limit);
  assign rd_addr  = cnt[IDX_W-1:0];
  assign hit_idx  = chk_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      chk_valid <= 1'b0;
    end else if (ctl.start) begin
      cnt       <= '0;
      chk_valid <= 1'b0;
    end else if (ctl.run) begin
      chk_valid <= rd_en;
      if (rd_en) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= cnt[IDX_W-1:0];
    end
  end

endmodule

@@ tb/sat_clause_state_tracker_unit_tb.sv @@
module sat_clause_state_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  localparam int MAX_LITS     = MAX_LITERALS_DEF;
  localparam int VAR_W        = VAR_BITS_DEF;
  localparam int RANDOM_WORDS = 1700;  // command words sent in the random part
  localparam int SETTLE       = 64;    // worst walk: match over the table plus unit search
  localparam int PLAN_LEN     = 26;

  // Status of the clause as one result word carries it; the field order matches
  // the concatenation of the result channel taken in the checker.
  typedef struct packed {
    logic               accepted;
    logic               conflict;
    logic               unit;
    logic [VAR_W-1:0]   unit_variable;
    logic               unit_polarity;
    logic [COUNT_W-1:0] true_count;
    logic [COUNT_W-1:0] false_count;
    logic [COUNT_W-1:0] unassigned_count;
    logic [COUNT_W-1:0] literal_count;
  } clause_status_t;

  // One directed command; 'typed' marks a row whose status is written out here
  // rather than worked out by the clause predictor.
  typedef struct packed {
    cmd_e             op;
    logic [VAR_W-1:0] var_id;
    logic             pol;
    logic             typed;
    clause_status_t   want;
  } step_row_t;

  localparam clause_status_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst;

  sct_cmd_if #(.VAR_BITS(VAR_W)) cmd_ch ();
  sct_res_if #(.VAR_BITS(VAR_W)) res_ch ();

  sat_clause_state_tracker_unit #(
    .MAX_LITERALS(MAX_LITS),
    .VAR_BITS    (VAR_W)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd_ch(cmd_ch),
    .res_ch(res_ch)
  );

  // 8 ns period: four high, four low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Clause predictor: its own copy of the literal table and the four totals.
  // Entries at or above lits_held are never read, so they need no reset.
  // ---------------------------------------------------------------------------
  logic [VAR_W-1:0] lit_var  [MAX_LITS];
  logic             lit_pol  [MAX_LITS];
  mark_e            lit_mark [MAX_LITS];
  int lits_held  = 0;
  int lits_true  = 0;
  int lits_false = 0;
  int lits_open  = 0;

  clause_status_t status_due [$];  // statuses still owed by the block, oldest first
  int  faults = 0;
  bit  steady = 1'b0;              // when set, neither side idles

  // Apply one command word to the predicted clause and return the status the
  // block must report for it.
  function automatic clause_status_t apply_command(cmd_e op, logic [VAR_W-1:0] v, logic p);
    clause_status_t s;
    int   hit;
    logic value;
    logic found;
    s     = '0;
    hit   = -1;
    found = 1'b0;
    if (op == CMD_ADD) begin
      // A full table drops the add.
      if (lits_held < MAX_LITS) begin
        lit_var[lits_held]  = v;
        lit_pol[lits_held]  = p;
        lit_mark[lits_held] = MARK_OPEN;
        lits_held++;
        lits_open++;
        s.accepted = 1'b1;
      end
    end else begin
      // Only the first entry on the variable is ever touched.
      for (int i = 0; i < lits_held; i++)
        if (hit < 0 && lit_var[i] == v) hit = i;
      if (hit >= 0) begin
        if (op == CMD_UNASSIGN) begin
          if (lit_mark[hit] != MARK_OPEN) begin
            if (lit_mark[hit] == MARK_TRUE) lits_true--;
            else lits_false--;
            lits_open++;
            lit_mark[hit] = MARK_OPEN;
            s.accepted    = 1'b1;
          end
        end else if (lit_mark[hit] == MARK_OPEN) begin
          // The literal is true when the value given matches its polarity.
          value = (op == CMD_TRUE);
          if (lit_pol[hit] == value) begin
            lit_mark[hit] = MARK_TRUE;
            lits_true++;
          end else begin
            lit_mark[hit] = MARK_FALSE;
            lits_false++;
          end
          lits_open--;
          s.accepted = 1'b1;
        end
      end
    end
    s.conflict = (lits_false == lits_held);
    s.unit     = (lits_held - lits_false == 1) && (lits_open == 1);
    if (s.unit) begin
      for (int i = 0; i < lits_held; i++)
        if (!found && lit_mark[i] == MARK_OPEN) begin
          s.unit_variable = lit_var[i];
          s.unit_polarity = lit_pol[i];
          found           = 1'b1;
        end
    end
    s.true_count       = COUNT_W'(lits_true);
    s.false_count      = COUNT_W'(lits_false);
    s.unassigned_count = COUNT_W'(lits_open);
    s.literal_count    = COUNT_W'(lits_held);
    return s;
  endfunction

  // Idle length for either side: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic string show(clause_status_t s);
    return $sformatf("acc=%0b conf=%0b unit=%0b uvar=%h upol=%0b t=%0d f=%0d o=%0d n=%0d",
                     s.accepted, s.conflict, s.unit, s.unit_variable, s.unit_polarity,
                     s.true_count, s.false_count, s.unassigned_count, s.literal_count);
  endfunction

  // Present one command word at the falling edge, hold it until the handshake,
  // and book its status at the edge that takes it. Valid stays high on return,
  // so a word that follows at once runs back to back.
  task automatic send_word(input cmd_e op, input logic [VAR_W-1:0] v, input logic p,
                           input logic typed, input clause_status_t want);
    int gap;
    clause_status_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.cmd         = op;
    cmd_ch.variable_id = v;
    cmd_ch.polarity    = p;
    cmd_ch.valid       = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = apply_command(op, v, p);
    status_due.insert(status_due.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every booked status has come back.
  task automatic drain_results();
    cmd_ch.valid = 1'b0;
    wait (status_due.size() == 0);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed commands. Rows with a typed status are the empty clause, the first
  // two adds and the add to a full table; the rest go through the predictor.
  // Table layout afterwards: entry 0 on FFFF, entry 1 on 0000, thirteen fills,
  // and entry 15 a second literal on 0000 that no command can ever reach.
  // ---------------------------------------------------------------------------
  step_row_t plan [PLAN_LEN] = '{
    // empty clause: no match, and no literals counts as all false
    '{CMD_TRUE,     16'h0005, 1'b0, 1'b1,
      {1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 5'd0, 5'd0, 5'd0, 5'd0}},
    // a lone open literal makes the clause unit on it
    '{CMD_ADD,      16'hFFFF, 1'b1, 1'b1,
      {1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b1, 5'd0, 5'd0, 5'd1, 5'd1}},
    '{CMD_ADD,      16'h0000, 1'b0, 1'b1,
      {1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 5'd0, 5'd0, 5'd2, 5'd2}},
    '{CMD_FALSE,    16'hFFFF, 1'b1, 1'b0, NO_WANT},  // false, unit on 0000
    '{CMD_FALSE,    16'hFFFF, 1'b0, 1'b0, NO_WANT},  // already assigned: dropped
    '{CMD_TRUE,     16'h0000, 1'b1, 1'b0, NO_WANT},  // negated literal false: conflict
    '{CMD_UNASSIGN, 16'h0000, 1'b0, 1'b0, NO_WANT},  // back from false
    '{CMD_UNASSIGN, 16'h0000, 1'b1, 1'b0, NO_WANT},  // already open: dropped
    '{CMD_FALSE,    16'h0000, 1'b0, 1'b0, NO_WANT},  // negated literal true
    '{CMD_UNASSIGN, 16'h0000, 1'b0, 1'b0, NO_WANT},  // back from true
    '{CMD_ADD,      16'h0001, 1'b1, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h8000, 1'b0, 1'b0, NO_WANT},
    '{CMD_ADD,      16'hA5A5, 1'b1, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h5A5A, 1'b0, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h00FF, 1'b1, 1'b0, NO_WANT},
    '{CMD_ADD,      16'hFF00, 1'b0, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h1234, 1'b1, 1'b0, NO_WANT},
    '{CMD_ADD,      16'hFFFE, 1'b0, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h7FFF, 1'b1, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h0F0F, 1'b0, 1'b0, NO_WANT},
    '{CMD_ADD,      16'hF0F0, 1'b1, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h3C3C, 1'b0, 1'b0, NO_WANT},
    '{CMD_ADD,      16'hC3C3, 1'b1, 1'b0, NO_WANT},
    '{CMD_ADD,      16'h0000, 1'b1, 1'b0, NO_WANT},  // duplicate variable, last slot
    // table full: add dropped, counts at their largest
    '{CMD_ADD,      16'h8001, 1'b1, 1'b1,
      {1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 5'd0, 5'd1, 5'd15, 5'd16}},
    '{CMD_TRUE,     16'h0000, 1'b0, 1'b0, NO_WANT}   // hits entry 1, not the duplicate
  };

  // ---------------------------------------------------------------------------
  // Command side: reset, the directed table, then random words.
  // ---------------------------------------------------------------------------
  initial begin : command_source
    cmd_e             op;
    logic [VAR_W-1:0] v;
    logic             p;
    logic             value;
    logic             shadowed;
    int               r;
    int               k;
    int               done_words;
    int               open_q  [$];
    int               true_q  [$];
    int               false_q [$];

    // Hold every input at a known value and keep reset high for a while.
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CMD_ADD;
    cmd_ch.variable_id = '0;
    cmd_ch.polarity    = 1'b0;
    done_words         = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i])
      send_word(plan[i].op, plan[i].var_id, plan[i].pol, plan[i].typed, plan[i].want);

    // Random part. The table is full from here on, so the work is assigning and
    // unassigning: drift most literals towards false so that unit clauses turn
    // up often, with a share of dropped commands and stray variables as noise.
    while (done_words < RANDOM_WORDS) begin
      // Drain the block completely at least once, and now and then at random.
      if (done_words == RANDOM_WORDS / 2 || $urandom_range(0, 299) == 0) drain_results();
      // Flip between idling and flat-out stretches.
      if ($urandom_range(0, 149) == 0) steady = ~steady;

      // Sort the reachable entries (first on their variable) by mark.
      open_q.delete();
      true_q.delete();
      false_q.delete();
      for (int i = 0; i < lits_held; i++) begin
        shadowed = 1'b0;
        for (int j = 0; j < i; j++)
          if (lit_var[j] == lit_var[i]) shadowed = 1'b1;
        if (!shadowed) begin
          case (lit_mark[i])
            MARK_OPEN: open_q.insert(open_q.size(), i);
            MARK_TRUE: true_q.insert(true_q.size(), i);
            default:   false_q.insert(false_q.size(), i);
          endcase
        end
      end

      p = 1'($urandom);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // add to the full table
        op = CMD_ADD;
        v  = VAR_W'($urandom);
      end else if (r < 14) begin
        // any variable at all, almost always a miss
        op = cmd_e'($urandom_range(1, 3));
        v  = VAR_W'($urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30 && true_q.size() > 0) begin
          k  = true_q[$urandom_range(0, true_q.size() - 1)];
          op = CMD_UNASSIGN;
        end else if (r < 75 && open_q.size() > 0) begin
          // mostly make the literal false, sometimes true
          k     = open_q[$urandom_range(0, open_q.size() - 1)];
          value = ($urandom_range(0, 99) < 85) ? ~lit_pol[k] : lit_pol[k];
          op    = value ? CMD_TRUE : CMD_FALSE;
        end else if (r < 95 && false_q.size() > 0) begin
          k  = false_q[$urandom_range(0, false_q.size() - 1)];
          op = CMD_UNASSIGN;
        end else begin
          // a command the entry's mark refuses
          k  = $urandom_range(0, lits_held - 1);
          op = (lit_mark[k] == MARK_OPEN) ? CMD_UNASSIGN : cmd_e'($urandom_range(1, 2));
        end
        v = lit_var[k];
      end

      send_word(op, v, p, 1'b0, NO_WANT);
      done_words++;
    end

    // Let the last results out, then give the block its longest walk to settle.
    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (faults == 0 && status_due.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: ready changes at the falling edge, with stalls of random length.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  // Compare each result word taken at a rising edge with the oldest status owed.
  always @(posedge clk) begin : status_check
    clause_status_t got;
    clause_status_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.accepted, res_ch.conflict, res_ch.unit, res_ch.unit_variable,
             res_ch.unit_polarity, res_ch.true_count, res_ch.false_count,
             res_ch.unassigned_count, res_ch.literal_count};
      if (status_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("%0t: result word with none owed: %s", $realtime, show(got));
      end else begin
        want = status_due.pop_front();
        if (got !== want) begin
          faults++;
          if (faults <= 10)
            $display("%0t: status mismatch\n  got  %s\n  want %s",
                     $realtime, show(got), show(want));
        end
      end
    end
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sat_clause_state_tracker_unit.f @@
src/sct_pkg.sv
src/sct_if.sv
src/sct_ram.sv
src/sct_scan.sv
src/sat_clause_state_tracker_unit.sv
tb/sat_clause_state_tracker_unit_tb.sv
